// ----- rtl/core/kspt_pkg.sv -----
package kspt_pkg;

  localparam int unsigned VAL_W = 17;
  localparam int unsigned KEY_W = 4;

  localparam logic [VAL_W-1:0] ACC_LIMIT     = 17'd9999;
  localparam logic [VAL_W-1:0] MIN_DUR_RESET = 17'd20;
  localparam logic [VAL_W-1:0] DUR_RESET     = 17'd20;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_EDIT      = 4'd10;
  localparam logic [KEY_W-1:0] KEY_START     = 4'd11;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  // lowest field last: relay_on sits in bit 0
  typedef struct packed {
    logic             key_ignored;
    logic [VAL_W-1:0] ticks_left;
    logic [VAL_W-1:0] pulse_length;
    logic             editing;
    logic             relay_on;
  } result_t;

endpackage

// ----- rtl/core/kspt_ctrl.sv -----
module kspt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kspt_pkg::VAL_W-1:0]    cfg_min,
  input  logic                          step_en,
  input  kspt_pkg::op_t                 op,
  input  logic [kspt_pkg::KEY_W-1:0]    key,
  output kspt_pkg::result_t             result
);

  logic [kspt_pkg::VAL_W-1:0] min_dur_r;
  logic [kspt_pkg::VAL_W-1:0] dur_r, dur_nxt;
  logic [kspt_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic [kspt_pkg::VAL_W-1:0] cnt_r, cnt_nxt;
  logic                       edit_r, edit_nxt;
  logic                       ignored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dur_r <= kspt_pkg::MIN_DUR_RESET;
      dur_r     <= kspt_pkg::DUR_RESET;
      acc_r     <= '0;
      cnt_r     <= '0;
      edit_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_dur_r <= cfg_min;
      end
      if (step_en) begin
        dur_r  <= dur_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        edit_r <= edit_nxt;
      end
    end
  end

  always_comb begin
    logic [kspt_pkg::VAL_W-1:0] acc_base;
    logic [kspt_pkg::VAL_W-1:0] dur_clamp;
    acc_base  = (acc_r > kspt_pkg::ACC_LIMIT) ? '0 : acc_r;
    dur_clamp = (dur_r < min_dur_r) ? min_dur_r : dur_r;
    dur_nxt   = dur_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    edit_nxt  = edit_r;
    ignored   = 1'b0;
    if (op == kspt_pkg::OP_TICK) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - {{(kspt_pkg::VAL_W-1){1'b0}}, 1'b1};
      end
    end else if (cnt_r != '0) begin
      ignored = 1'b1;
    end else if (key <= kspt_pkg::KEY_DIGIT_MAX) begin
      if (edit_r) begin
        acc_nxt = (acc_base << 3) + (acc_base << 1)
                + {{(kspt_pkg::VAL_W-kspt_pkg::KEY_W){1'b0}}, key};
        dur_nxt = acc_nxt;
      end
    end else if (key == kspt_pkg::KEY_EDIT) begin
      edit_nxt = !edit_r;
      if (!edit_r) begin
        acc_nxt = '0;
      end else begin
        dur_nxt = dur_clamp;
      end
    end else if (key == kspt_pkg::KEY_START) begin
      edit_nxt = 1'b0;
      dur_nxt  = dur_clamp;
      cnt_nxt  = dur_clamp;
    end
  end

  always_comb begin
    result.relay_on     = (cnt_nxt != '0);
    result.editing      = edit_nxt;
    result.pulse_length = dur_nxt;
    result.ticks_left   = cnt_nxt;
    result.key_ignored  = ignored;
  end

endmodule

// ----- rtl/core/keypad_set_relay_pulse_timer.sv -----
// An accepted input beat goes through the input register and the result register
// (on out_tvalid), each holding one beat. Throughput: one beat per cycle unless
// out_tready stalls; the two advance together when the result register is free.
// Reset (rst_n low at a rising edge) empties both registers and sets
// duration 20, min_duration 20, countdown 0, edit mode off.
module keypad_set_relay_pulse_timer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kspt_pkg::VAL_W-1:0] cfg_data,   // min_duration
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [3:0] key_code, [7:4] zero
  input  logic [0:0]                 in_tuser,   // [0] operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] relay_on, [1] editing, [18:2] pulse_length, [35:19] ticks_left,
  // [36] key_ignored, [39:37] zero
  output logic [39:0]                out_tdata
);

  logic                           in_v_r;
  logic                           in_op_r;
  logic [kspt_pkg::KEY_W-1:0]     in_key_r;
  logic                           out_v_r;
  logic [39:0]                    out_data_r;
  logic                           adv;
  kspt_pkg::result_t              result;

  assign cfg_ready  = 1'b1;
  assign adv        = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r  <= in_tuser[0];
      in_key_r <= in_tdata[kspt_pkg::KEY_W-1:0];
    end
    if (adv) begin
      out_data_r <= {3'b000, result};
    end
  end

  kspt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_min (cfg_data),
    .step_en (adv),
    .op      (kspt_pkg::op_t'(in_op_r)),
    .key     (in_key_r),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  a_relay_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[35:19] != '0)))
    else $error("relay_on disagrees with ticks_left");

  a_ignored_only_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[36]) |-> out_tdata[0])
    else $error("key ignored while no pulse runs");

  a_no_edit_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("edit mode active during a pulse");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> (in_v_r && $stable(in_key_r) && $stable(in_op_r)))
    else $error("stalled input beat lost");
`endif

endmodule
